// ===== hdl/lamport_ordered_request_queue_assert.svh =====
`ifndef LAMPORT_ORDERED_REQUEST_QUEUE_ASSERT_SVH
`define LAMPORT_ORDERED_REQUEST_QUEUE_ASSERT_SVH

// Condition must never be seen outside reset.
`define LORQ_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LORQ_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lorq_pkg.sv =====
package lorq_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NODE_W    = 4;
  localparam int STAMP_W   = 32;
  localparam int ACK_W     = 4;
  localparam int CFG_W     = 5;
  localparam int REG_IDX_W = 2;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_ACK     = 2'd2,
    FUNC_START   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_OWN_NODE    = 2'd0,
    REG_NODE_COUNT  = 2'd1,
    REG_GRANT_SLOTS = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_POST
  } state_t;

  typedef struct packed {
    func_t               func;
    logic [STAMP_W-1:0]  stamp;
    logic [NODE_W-1:0]   sender;
  } req_t;

  typedef struct packed {
    logic [STAMP_W-1:0]  clock_now;
    logic                send_ack;
    logic                granted;
    logic [CNT_W-1:0]    own_place;
    status_t             status;
  } rsp_t;

  // Per-cycle command shared by every cell of the chain.
  typedef struct packed {
    logic cmp;
    logic shift;
    logic insert;
  } cell_ctrl_t;

endpackage

// ===== hdl/lorq_cell.sv =====
module lorq_cell (
  input  logic                          clk,
  input  lorq_pkg::cell_ctrl_t          ctrl,
  input  logic                          valid,
  input  logic [lorq_pkg::STAMP_W-1:0]  key_stamp,
  input  logic [lorq_pkg::NODE_W-1:0]   key_node,
  input  logic [lorq_pkg::STAMP_W-1:0]  load_stamp,
  input  logic [lorq_pkg::NODE_W-1:0]   load_node,
  input  logic [lorq_pkg::NODE_W-1:0]   own_node,
  input  logic [lorq_pkg::STAMP_W-1:0]  left_stamp,
  input  logic [lorq_pkg::NODE_W-1:0]   left_node,
  input  logic                          left_move,
  input  logic [lorq_pkg::STAMP_W-1:0]  right_stamp,
  input  logic [lorq_pkg::NODE_W-1:0]   right_node,
  input  logic                          seen_in,
  output logic [lorq_pkg::STAMP_W-1:0]  stamp,
  output logic [lorq_pkg::NODE_W-1:0]   node,
  output logic                          move,
  output logic                          seen_out,
  output logic                          own_hit
);
  import lorq_pkg::*;

  logic gt;
  logic match;
  logic move_next;

  assign gt       = valid && ((stamp > key_stamp) ||
                              ((stamp == key_stamp) && (node > key_node)));
  assign match    = valid && (node == key_node);
  assign seen_out = seen_in | match;
  assign own_hit  = valid && (node == own_node);

  // Insert: every cell from the insertion point on moves. Release: every cell
  // from the first match of the sender on moves.
  assign move_next = ctrl.insert ? (gt || !valid) : seen_out;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      move <= move_next;
    end
    if (ctrl.shift && move) begin
      if (ctrl.insert) begin
        if (left_move) begin
          stamp <= left_stamp;
          node  <= left_node;
        end else begin
          stamp <= load_stamp;
          node  <= load_node;
        end
      end else begin
        stamp <= right_stamp;
        node  <= right_node;
      end
    end
  end

endmodule

// ===== hdl/lamport_ordered_request_queue.sv =====
// Lamport-ordered request queue. Each message passes from its transfer on the
// input to its result in the output register through a compare step, which
// compares the message key against every cell of the sorted chain (and steps
// the Lamport clock), a shift step, which shifts the chain, and a post step,
// which finds this node's own place and updates the acknowledge and grant
// state. A new message is taken when the chain is idle, even while the
// previous result waits on the output; a result is held in the post step only
// while the output register is still occupied. Queue cells hold data from the
// first write only, so the block needs no clearing pass after reset.
`include "lamport_ordered_request_queue_assert.svh"

module lamport_ordered_request_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lorq_pkg::req_t                  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lorq_pkg::rsp_t                  out_data,
  input  logic                            cfg_we,
  input  logic [lorq_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [lorq_pkg::CFG_W-1:0]      cfg_data
);
  import lorq_pkg::*;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  state_t state, state_next;

  logic [NODE_W-1:0]  own_node;
  logic [CFG_W-1:0]   node_count;
  logic [CFG_W-1:0]   grant_slots;

  req_t               req_q;
  logic               full_q;
  logic               found_q;
  logic [CNT_W-1:0]   entry_count;
  logic [STAMP_W-1:0] lamport_clock;
  logic [STAMP_W-1:0] lamport_clock_next;
  logic [ACK_W-1:0]   acks_seen;
  logic [ACK_W-1:0]   acks_seen_next;
  logic               acks_complete;
  logic               grant_held;

  logic               accept;
  logic               load_out;
  cell_ctrl_t         ctrl;

  logic [STAMP_W-1:0] cell_stamp [MAX_NODES];
  logic [NODE_W-1:0]  cell_node  [MAX_NODES];
  logic               cell_move  [MAX_NODES];
  logic               cell_seen  [MAX_NODES];
  logic [MAX_NODES-1:0] cell_valid;
  logic [MAX_NODES-1:0] cell_hit;

  logic [CNT_W-1:0]   own_place;
  logic               own_absent;
  logic               own_in_slots;
  logic [CFG_W-1:0]   acks_need;
  logic               acks_reached;

  assign accept = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node    <= '0;
      node_count  <= CFG_W'(1);
      grant_slots <= CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_NODE:    own_node    <= cfg_data[NODE_W-1:0];
        REG_NODE_COUNT:  node_count  <= cfg_data;
        REG_GRANT_SLOTS: grant_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SHIFT;
      ST_SHIFT: state_next = ST_POST;
      ST_POST:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready   = 1'b0;
    ctrl.cmp   = 1'b0;
    ctrl.shift = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.cmp = in_valid;
      end
      ST_SHIFT: begin
        ctrl.shift = ((req_q.func == FUNC_REQUEST) && !full_q) ||
                     ((req_q.func == FUNC_RELEASE) && found_q);
      end
      ST_POST: begin
        load_out = !out_valid || out_ready;
      end
      default: ;
    endcase
    ctrl.insert = (state == ST_IDLE) ? (in_data.func == FUNC_REQUEST)
                                     : (req_q.func == FUNC_REQUEST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lamport clock, saturating
  always_comb begin
    if (in_data.stamp > lamport_clock) begin
      lamport_clock_next = (in_data.stamp == STAMP_MAX) ? in_data.stamp
                                                        : in_data.stamp + 1'b1;
    end else begin
      lamport_clock_next = (lamport_clock == STAMP_MAX) ? lamport_clock
                                                        : lamport_clock + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= in_data;
      full_q <= (entry_count == CNT_W'(MAX_NODES));
    end
    if (ctrl.cmp) begin
      found_q <= cell_seen[MAX_NODES-1];
    end
  end

  // Cell chain
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      cell_valid[i] = CNT_W'(i) < entry_count;
    end
  end

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    logic [STAMP_W-1:0] left_stamp;
    logic [NODE_W-1:0]  left_node;
    logic               left_move;
    logic [STAMP_W-1:0] right_stamp;
    logic [NODE_W-1:0]  right_node;
    logic               seen_in;

    if (g == 0) begin : g_first
      assign left_stamp = req_q.stamp;
      assign left_node  = req_q.sender;
      assign left_move  = 1'b0;
      assign seen_in    = 1'b0;
    end else begin : g_inner
      assign left_stamp = cell_stamp[g-1];
      assign left_node  = cell_node[g-1];
      assign left_move  = cell_move[g-1];
      assign seen_in    = cell_seen[g-1];
    end

    if (g == MAX_NODES - 1) begin : g_last
      assign right_stamp = cell_stamp[g];
      assign right_node  = cell_node[g];
    end else begin : g_body
      assign right_stamp = cell_stamp[g+1];
      assign right_node  = cell_node[g+1];
    end

    lorq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (cell_valid[g]),
      .key_stamp   (in_data.stamp),
      .key_node    (in_data.sender),
      .load_stamp  (req_q.stamp),
      .load_node   (req_q.sender),
      .own_node    (own_node),
      .left_stamp  (left_stamp),
      .left_node   (left_node),
      .left_move   (left_move),
      .right_stamp (right_stamp),
      .right_node  (right_node),
      .seen_in     (seen_in),
      .stamp       (cell_stamp[g]),
      .node        (cell_node[g]),
      .move        (cell_move[g]),
      .seen_out    (cell_seen[g]),
      .own_hit     (cell_hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (ctrl.shift) begin
      if (ctrl.insert) begin
        entry_count <= entry_count + 1'b1;
      end else begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // Own place: first hit in the chain
  always_comb begin
    own_place = CNT_W'(MAX_NODES);
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        own_place = CNT_W'(i);
      end
    end
  end

  assign own_absent   = (own_place == CNT_W'(MAX_NODES));
  assign own_in_slots = !own_absent && ({{(CFG_W-CNT_W+1){1'b0}}, own_place} <
                                        {1'b0, grant_slots});
  assign acks_need    = (node_count == '0) ? '0 : node_count - 1'b1;
  assign acks_seen_next = (acks_seen == '1) ? acks_seen : acks_seen + 1'b1;
  assign acks_reached = {{(CFG_W-ACK_W){1'b0}}, acks_seen_next} >= acks_need;

  // Lamport clock and acknowledge / grant state
  always_ff @(posedge clk) begin
    if (rst) begin
      lamport_clock <= '0;
      acks_seen     <= '0;
      acks_complete <= 1'b0;
      grant_held    <= 1'b0;
    end else begin
      if (accept) begin
        lamport_clock <= lamport_clock_next;
      end
      if (load_out) begin
        case (req_q.func)
          FUNC_RELEASE: begin
            if (own_absent) begin
              grant_held <= 1'b0;
            end else if (acks_complete && own_in_slots) begin
              grant_held <= 1'b1;
            end
          end
          FUNC_ACK: begin
            if (!acks_complete) begin
              acks_seen <= acks_seen_next;
              if (acks_reached) begin
                acks_complete <= 1'b1;
                if (own_in_slots) begin
                  grant_held <= 1'b1;
                end
              end
            end
          end
          FUNC_START: begin
            acks_seen     <= '0;
            acks_complete <= 1'b0;
            grant_held    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.clock_now <= lamport_clock;
      out_data.send_ack  <= (req_q.func == FUNC_REQUEST);
      out_data.own_place <= own_place;
      case (req_q.func)
        FUNC_REQUEST: out_data.status <= full_q ? STATUS_FULL : STATUS_OK;
        FUNC_RELEASE: out_data.status <= found_q ? STATUS_OK : STATUS_ABSENT;
        default:      out_data.status <= STATUS_OK;
      endcase
      case (req_q.func)
        FUNC_RELEASE: begin
          out_data.granted <= own_absent ? 1'b0
                              : ((acks_complete && own_in_slots) | grant_held);
        end
        FUNC_ACK: begin
          out_data.granted <= (!acks_complete && acks_reached && own_in_slots)
                              | grant_held;
        end
        FUNC_START: out_data.granted <= 1'b0;
        default:    out_data.granted <= grant_held;
      endcase
    end
  end

  `LORQ_ASSERT_NEVER(a_count_range, entry_count > CNT_W'(MAX_NODES),
    "queue holds more entries than cells")
  `LORQ_ASSERT_IMPLY(a_grant_needs_acks, grant_held, acks_complete,
    "grant held without all acknowledges")
  `LORQ_ASSERT_IMPLY(a_shift_follows_transfer, state == ST_SHIFT,
    $past(in_valid && in_ready), "shift step without an input transfer")

endmodule

// ===== verif/lamport_ordered_request_queue_tb.sv =====
`timescale 1ns / 1ps

module lamport_ordered_request_queue_tb;
  import lorq_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 148;

  typedef struct {
    bit   pinned;
    rsp_t want;
  } pin_t;

  typedef struct {
    func_t        f;
    logic [31:0]  s;
    logic [3:0]   who;
    bit           pinned;
    rsp_t         want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  req_t                  in_data;
  logic                  out_valid;
  logic                  out_ready;
  rsp_t                  out_data;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  lamport_ordered_request_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the block's configuration and queue state.
  logic [3:0]   own_id    = 4'd0;
  logic [4:0]   nodes_cfg = 5'd1;
  logic [4:0]   slots_cfg = 5'd1;
  logic [31:0]  q_stamp [MAX_NODES];
  logic [3:0]   q_node  [MAX_NODES];
  int           q_cnt         = 0;
  logic [31:0]  lclock        = 32'd0;
  int           acks_seen     = 0;
  bit           acks_complete = 1'b0;
  bit           grant_held    = 1'b0;

  rsp_t         pending_results [$];
  pin_t         pins [$];
  int           n_sent    = 0;
  int           n_checked = 0;
  int           fail_count = 0;

  int           idle_pct  = 21;
  int           hold_req  = 0;
  int           hold_done = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  // Stimulus-side view: senders currently queued, and the running clock.
  logic [3:0]   queued_nodes [$];
  logic [31:0]  gen_clock = 32'd0;

  // Directed rows, starting from the reset configuration (own 0, one node, one slot).
  row_t script [17] = '{
    '{FUNC_ACK,     32'd0,          4'd3,  1'b1, '{32'd1,  1'b0, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd5,  1'b1, '{32'd2,  1'b0, 1'b0, 5'd16, STATUS_ABSENT}},
    '{FUNC_REQUEST, 32'd10,         4'd15, 1'b1, '{32'd11, 1'b1, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_REQUEST, 32'd10,         4'd0,  1'b1, '{32'd12, 1'b1, 1'b0, 5'd0,  STATUS_OK}},
    '{FUNC_ACK,     32'd0,          4'd1,  1'b1, '{32'd13, 1'b0, 1'b0, 5'd0,  STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd15, 1'b1, '{32'd14, 1'b0, 1'b1, 5'd0,  STATUS_OK}},
    '{FUNC_START,   32'd0,          4'd9,  1'b1, '{32'd15, 1'b0, 1'b0, 5'd0,  STATUS_OK}},
    '{FUNC_REQUEST, 32'd15,         4'd4,  1'b1, '{32'd16, 1'b1, 1'b0, 5'd0,  STATUS_OK}},
    '{FUNC_REQUEST, 32'd3,          4'd7,  1'b1, '{32'd17, 1'b1, 1'b0, 5'd1,  STATUS_OK}},
    '{FUNC_ACK,     32'd0,          4'd2,  1'b1, '{32'd18, 1'b0, 1'b0, 5'd1,  STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd7,  1'b1, '{32'd19, 1'b0, 1'b1, 5'd0,  STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd0,  1'b1, '{32'd20, 1'b0, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd4,  1'b1, '{32'd21, 1'b0, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_REQUEST, 32'h8000_0000,  4'd9,  1'b1,
      '{32'h8000_0001, 1'b1, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_REQUEST, 32'h8000_0000,  4'd2,  1'b1,
      '{32'h8000_0002, 1'b1, 1'b0, 5'd16, STATUS_OK}},
    '{FUNC_RELEASE, 32'd0,          4'd9,  1'b0, '0},
    '{FUNC_RELEASE, 32'd0,          4'd2,  1'b0, '0}
  };

  function automatic int locate(logic [3:0] who);
    int i;
    for (i = 0; i < q_cnt; i++)
      if (q_node[i] == who) return i;
    return MAX_NODES;
  endfunction

  // Advance the shadow state by one message and return the result it produces.
  function automatic rsp_t lamport_next(req_t m);
    rsp_t r;
    int   p, i, need, own_pos;
    r = '0;
    if (m.stamp > lclock)
      lclock = (m.stamp == 32'hFFFF_FFFF) ? m.stamp : m.stamp + 32'd1;
    else if (lclock != 32'hFFFF_FFFF)
      lclock = lclock + 32'd1;
    r.status = STATUS_OK;
    case (m.func)
      FUNC_REQUEST: begin
        r.send_ack = 1'b1;
        if (q_cnt >= MAX_NODES) begin
          r.status = STATUS_FULL;
        end else begin
          // Insert after every key less than or equal to (stamp, sender).
          p = 0;
          while (p < q_cnt && !(q_stamp[p] > m.stamp ||
                 (q_stamp[p] == m.stamp && q_node[p] > m.sender)))
            p++;
          for (i = q_cnt; i > p; i--) begin
            q_stamp[i] = q_stamp[i-1];
            q_node[i]  = q_node[i-1];
          end
          q_stamp[p] = m.stamp;
          q_node[p]  = m.sender;
          q_cnt++;
        end
      end
      FUNC_RELEASE: begin
        p = locate(m.sender);
        if (p >= MAX_NODES) begin
          r.status = STATUS_ABSENT;
        end else begin
          for (i = p; i + 1 < q_cnt; i++) begin
            q_stamp[i] = q_stamp[i+1];
            q_node[i]  = q_node[i+1];
          end
          q_cnt--;
        end
        own_pos = locate(own_id);
        if (own_pos >= MAX_NODES)
          grant_held = 1'b0;
        else if (acks_complete && own_pos < int'(slots_cfg))
          grant_held = 1'b1;
      end
      FUNC_ACK: begin
        if (!acks_complete) begin
          need = (nodes_cfg == 0) ? 0 : int'(nodes_cfg) - 1;
          if (acks_seen < 15) acks_seen++;
          if (acks_seen >= need) begin
            acks_complete = 1'b1;
            own_pos = locate(own_id);
            if (own_pos < MAX_NODES && own_pos < int'(slots_cfg)) grant_held = 1'b1;
          end
        end
      end
      default: begin
        acks_seen     = 0;
        acks_complete = 1'b0;
        grant_held    = 1'b0;
      end
    endcase
    r.clock_now = lclock;
    r.granted   = grant_held;
    r.own_place = 5'(locate(own_id));
    return r;
  endfunction

  // Predict on every input transfer, check on every output transfer.
  always @(posedge clk) begin : check_results
    rsp_t pred;
    rsp_t want;
    pin_t pin;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pred = lamport_next(in_data);
        pin  = pins.pop_front();
        pending_results.push_back(pin.pinned ? pin.want : pred);
      end
      if (out_valid && out_ready) begin
        n_checked++;
        if (pending_results.size() == 0) begin
          $error("result transfer with no expected result: %p", out_data);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.clock_now !== want.clock_now) begin
            $error("clock_now: expected %0h, actual %0h", want.clock_now, out_data.clock_now);
            fail_count++;
          end
          if (out_data.send_ack !== want.send_ack) begin
            $error("send_ack: expected %0b, actual %0b", want.send_ack, out_data.send_ack);
            fail_count++;
          end
          if (out_data.granted !== want.granted) begin
            $error("granted: expected %0b, actual %0b", want.granted, out_data.granted);
            fail_count++;
          end
          if (out_data.own_place !== want.own_place) begin
            $error("own_place: expected %0d, actual %0d", want.own_place, out_data.own_place);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %s, actual %s", want.status.name(),
                   out_data.status.name());
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done < hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic logic [3:0] rand_node();
    return 4'($urandom_range(15));
  endfunction

  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(39))
      0:       return 32'($urandom_range(32'hEFFF_FFFF));
      1, 2, 3: return 32'($urandom_range(15));
      default: begin
        if ($urandom_range(1) == 0 && gen_clock > 32'd2)
          return gen_clock - 32'($urandom_range(2));
        return gen_clock + 32'($urandom_range(1, 5));
      end
    endcase
  endfunction

  task automatic offer(input func_t f, input logic [31:0] s, input logic [3:0] who,
                       input bit pinned = 1'b0, input rsp_t want = '0);
    int gap;
    int i;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, stamp: s, sender: who};
    pins.push_back('{pinned, want});
    n_sent++;
    do @(posedge clk); while (!in_ready);
    if (f == FUNC_REQUEST && queued_nodes.size() < MAX_NODES) begin
      queued_nodes.push_back(who);
    end else if (f == FUNC_RELEASE) begin
      for (i = 0; i < queued_nodes.size(); i++)
        if (queued_nodes[i] == who) begin
          queued_nodes.delete(i);
          break;
        end
    end
    if (s > gen_clock) gen_clock = s;
    if (gen_clock != 32'hFFFF_FFFF) gen_clock++;
  endtask

  task automatic release_one();
    if (queued_nodes.size() > 0)
      offer(FUNC_RELEASE, pick_stamp(),
            queued_nodes[$urandom_range(queued_nodes.size() - 1)]);
    else
      offer(FUNC_RELEASE, pick_stamp(), rand_node());
  endtask

  // One well-formed round: start, own request, acks mixed with other traffic, leave.
  task automatic own_round();
    int acks;
    int i;
    offer(FUNC_START, pick_stamp(), rand_node());
    offer(FUNC_REQUEST, pick_stamp(), own_id);
    acks = int'(nodes_cfg) - 1 + $urandom_range(1);
    for (i = 0; i < acks; i++) begin
      if ($urandom_range(3) == 0) begin
        if ($urandom_range(9) < 6) offer(FUNC_REQUEST, pick_stamp(), rand_node());
        else release_one();
      end
      offer(FUNC_ACK, pick_stamp(), rand_node());
    end
    repeat ($urandom_range(3)) release_one();
    offer(FUNC_RELEASE, pick_stamp(), own_id);
  endtask

  // Fill the queue, overflow it, then drain part of it.
  task automatic fill_burst();
    while (queued_nodes.size() < MAX_NODES)
      offer(FUNC_REQUEST, pick_stamp(), rand_node());
    repeat ($urandom_range(1, 3)) offer(FUNC_REQUEST, pick_stamp(), rand_node());
    repeat ($urandom_range(4, 16)) release_one();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input logic [4:0] own, input logic [4:0] nodes,
                             input logic [4:0] slots);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OWN_NODE;
    cfg_data  <= own;
    @(posedge clk);
    own_id     = own[3:0];
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= nodes;
    @(posedge clk);
    nodes_cfg  = nodes;
    cfg_index <= REG_GRANT_SLOTS;
    cfg_data  <= slots;
    @(posedge clk);
    slots_cfg  = slots;
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int ph;
    int target;
    int r;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_OWN_NODE;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      offer(script[i].f, script[i].s, script[i].who, script[i].pinned, script[i].want);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1:       load_config(5'd15, 5'd16, 5'd16);
          2:       load_config(5'd0,  5'd16, 5'd1);
          3:       load_config(5'd15, 5'd1,  5'd1);
          4:       load_config(5'd0,  5'd1,  5'd16);
          default: load_config(5'($urandom_range(15)), 5'($urandom_range(1, 16)),
                               5'($urandom_range(1, 16)));
        endcase
      end
      idle_pct = (ph == 1) ? 0 : 21;
      if (ph == 2) begin
        // Stall the result side while requests keep coming.
        hold_req++;
        fill_burst();
      end
      target = n_sent + PHASE_ITEMS;
      while (n_sent < target) begin
        r = $urandom_range(99);
        if (r < 70) own_round();
        else if (r < 73) fill_burst();
        else repeat ($urandom_range(1, 4))
          offer(func_t'($urandom_range(3)), pick_stamp(), rand_node());
      end
    end

    // Clock saturation last: the clock never comes back down.
    offer(FUNC_REQUEST, 32'hFFFF_FFFF, 4'd15);
    offer(FUNC_ACK, 32'hFFFF_FFFE, 4'd0);
    offer(FUNC_START, 32'd0, own_id);
    offer(FUNC_REQUEST, 32'hFFFF_FFFF, own_id);
    offer(FUNC_RELEASE, 32'd0, own_id);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
